// ===== rtl/ffds_pkg.sv =====
// Shared types and constants for the farthest-first depth sorter.
// Used by the sorter, store and distance modules; depends on nothing else.
package ffds_pkg;

    // Coordinate and distance widths (signed 16.4 fixed point coordinates).
    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int DIST_W  = SQ_W + 1;
    localparam int CFG_W   = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic [4:0]                t_obj_idx;
    typedef logic [CFG_W-1:0]          t_cfg_idx;

    // One stored object: position and the empty-space flag.
    typedef struct packed {
        logic   in_empty;
        t_coord pos_z;
        t_coord pos_y;
        t_coord pos_x;
    } t_obj;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_VIEW_X       = 2'd0;
    localparam t_cfg_idx CFG_VIEW_Y       = 2'd1;
    localparam t_cfg_idx CFG_VIEW_Z       = 2'd2;
    localparam t_cfg_idx CFG_SELECT_WATER = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/farthest_first_depth_sorter.sv =====
// Top level of the farthest-first depth sorter: sequencer, marks and result register.
// Depends on ffds_pkg, ffds_store and ffds_dist.
//
// Objects are loaded one per cycle into an on-chip store of MAX_OBJECTS entries;
// objects past that depth are dropped. The object that carries last_object starts
// a run: the block repeatedly scans the store, one memory read per stored object,
// through the registered read and the squared-distance pipeline, and emits the index of
// the farthest unmarked object of the selected class (ties go to the lower index,
// zero distance never qualifies). A run that emits K objects ends with a terminator
// result, and a result may wait on a stalled output register.
// Input is stalled for the whole run; loading resumes in the cycle after the
// terminator enters the output register.
module farthest_first_depth_sorter #(
    parameter int MAX_OBJECTS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Object input channel.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [19:0]      i_pos_x,
    input  logic signed [19:0]      i_pos_y,
    input  logic signed [19:0]      i_pos_z,
    input  logic                    i_in_empty,
    input  logic                    i_last_object,
    // Result output channel.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [4:0]              o_object_index,
    output logic                    o_has_object,
    output logic                    o_last_result,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [19:0]             i_cfg_data
);

    localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

    ffds_pkg::t_state   r_state, n_state;
    ffds_pkg::t_coord   r_view_x, r_view_y, r_view_z;
    logic               r_sel_water;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_iss;
    logic [MAX_OBJECTS-1:0] r_marks;
    logic               r_p1_valid, r_p1_unmk;
    logic [IDX_W-1:0]   r_p1_idx;
    ffds_pkg::t_dist    r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_out_valid, r_out_has, r_out_last;
    ffds_pkg::t_obj_idx r_out_idx;

    logic               in_xfer, out_free, iss_en, emit, found;
    logic               store_wr;
    ffds_pkg::t_obj     wr_obj, rd_obj;
    logic               dist_in_valid, dist_valid, dist_busy;
    logic [IDX_W-1:0]   dist_idx;
    ffds_pkg::t_dist    dist_val;

    // Handshakes.
    assign o_in_stall  = (r_state != ffds_pkg::ST_LOAD);
    assign in_xfer     = i_in_valid && (r_state == ffds_pkg::ST_LOAD);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign found       = (r_best != '0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x    <= '0;
            r_view_y    <= '0;
            r_view_z    <= '0;
            r_sel_water <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ffds_pkg::CFG_VIEW_X:       r_view_x    <= i_cfg_data;
                ffds_pkg::CFG_VIEW_Y:       r_view_y    <= i_cfg_data;
                ffds_pkg::CFG_VIEW_Z:       r_view_z    <= i_cfg_data;
                ffds_pkg::CFG_SELECT_WATER: r_sel_water <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state and sequencer controls.
    always_comb begin
        n_state = r_state;
        iss_en  = 1'b0;
        emit    = 1'b0;
        case (r_state)
            ffds_pkg::ST_LOAD: begin
                if (in_xfer && i_last_object) begin
                    n_state = ffds_pkg::ST_SCAN;
                end
            end
            ffds_pkg::ST_SCAN: begin
                iss_en = 1'b1;
                if (CNT_W'(r_iss) + CNT_W'(1) == r_count) begin
                    n_state = ffds_pkg::ST_DRAIN;
                end
            end
            ffds_pkg::ST_DRAIN: begin
                if (!r_p1_valid && !dist_busy) begin
                    n_state = ffds_pkg::ST_EMIT;
                end
            end
            ffds_pkg::ST_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = found ? ffds_pkg::ST_SCAN : ffds_pkg::ST_LOAD;
                end
            end
            default: n_state = ffds_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffds_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Object count and store write; objects past the depth are dropped.
    assign store_wr        = in_xfer && (r_count < CNT_W'(MAX_OBJECTS));
    assign wr_obj.in_empty = i_in_empty;
    assign wr_obj.pos_x    = i_pos_x;
    assign wr_obj.pos_y    = i_pos_y;
    assign wr_obj.pos_z    = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (emit && !found) begin
            r_count <= '0;
        end else if (store_wr) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    ffds_store #(
        .DEPTH (MAX_OBJECTS),
        .AW    (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_obj),
        .i_rd_addr (r_iss),
        .o_rd_data (rd_obj)
    );

    // Scan address and the tags that line up with the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss      <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            r_iss      <= iss_en ? r_iss + 1'b1 : '0;
            r_p1_valid <= iss_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx  <= r_iss;
        r_p1_unmk <= !r_marks[r_iss];
    end

    // Only unmarked objects of the selected class enter the distance pipeline.
    assign dist_in_valid = r_p1_valid && r_p1_unmk && (rd_obj.in_empty ^ r_sel_water);

    ffds_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dist_in_valid),
        .i_idx    (r_p1_idx),
        .i_obj    (rd_obj),
        .i_view_x (r_view_x),
        .i_view_y (r_view_y),
        .i_view_z (r_view_z),
        .o_valid  (dist_valid),
        .o_idx    (dist_idx),
        .o_dist   (dist_val),
        .o_busy   (dist_busy)
    );

    // Running maximum; strict compare keeps the lower index on a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (emit) begin
            r_best <= '0;
        end else if (dist_valid && (dist_val > r_best)) begin
            r_best <= dist_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dist_valid && (dist_val > r_best)) begin
            r_best_idx <= dist_idx;
        end
    end

    // Emitted marks: set per result, cleared when the run ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (emit) begin
            if (found) begin
                r_marks[r_best_idx] <= 1'b1;
            end else begin
                r_marks <= '0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx  <= found ? ffds_pkg::t_obj_idx'(r_best_idx) : '0;
            r_out_has  <= found;
            r_out_last <= !found;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_object_index = r_out_idx;
    assign o_has_object   = r_out_has;
    assign o_last_result  = r_out_last;

endmodule

// ===== rtl/ffds_store.sv =====
// Object store: one synchronous memory with a registered read port.
// Depends on ffds_pkg for the stored object type.
module ffds_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  ffds_pkg::t_obj i_wr_data,
    input  logic [AW-1:0]  i_rd_addr,
    output ffds_pkg::t_obj o_rd_data
);

    ffds_pkg::t_obj r_mem [DEPTH];
    ffds_pkg::t_obj r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ffds_dist.sv =====
// Squared-distance pipeline: difference, square and sum stages.
// Depends on ffds_pkg for coordinate and distance widths.
module ffds_dist #(
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_idx,
    input  ffds_pkg::t_obj   i_obj,
    input  ffds_pkg::t_coord i_view_x,
    input  ffds_pkg::t_coord i_view_y,
    input  ffds_pkg::t_coord i_view_z,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_idx,
    output ffds_pkg::t_dist  o_dist,
    output logic             o_busy
);

    localparam int DW = ffds_pkg::DIFF_W;
    localparam int SW = ffds_pkg::SQ_W;

    logic                  r_d_valid, r_s_valid, r_t_valid;
    logic [IDX_W-1:0]      r_d_idx, r_s_idx, r_t_idx;
    logic signed [DW-1:0]  r_dx, r_dy, r_dz;
    logic [SW-1:0]         r_sx, r_sy, r_sz;
    ffds_pkg::t_dist       r_sum;
    logic signed [2*DW-1:0] sq_x, sq_y, sq_z;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_t_valid <= 1'b0;
        end else begin
            r_d_valid <= i_valid;
            r_s_valid <= r_d_valid;
            r_t_valid <= r_s_valid;
        end
    end

    // Stage one: exact signed differences.
    always_ff @(posedge i_clk) begin
        r_d_idx <= i_idx;
        r_dx    <= $signed({i_obj.pos_x[19], i_obj.pos_x}) - $signed({i_view_x[19], i_view_x});
        r_dy    <= $signed({i_obj.pos_y[19], i_obj.pos_y}) - $signed({i_view_y[19], i_view_y});
        r_dz    <= $signed({i_obj.pos_z[19], i_obj.pos_z}) - $signed({i_view_z[19], i_view_z});
    end

    // Stage two: one multiplier per axis; a square is never negative.
    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign sq_z = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_s_idx <= r_d_idx;
        r_sx    <= sq_x[SW-1:0];
        r_sy    <= sq_y[SW-1:0];
        r_sz    <= sq_z[SW-1:0];
    end

    // Stage three: sum of the three squares.
    always_ff @(posedge i_clk) begin
        r_t_idx <= r_s_idx;
        r_sum   <= ffds_pkg::DIST_W'(r_sx) + ffds_pkg::DIST_W'(r_sy)
                 + ffds_pkg::DIST_W'(r_sz);
    end

    assign o_valid = r_t_valid;
    assign o_idx   = r_t_idx;
    assign o_dist  = r_sum;
    assign o_busy  = r_d_valid | r_s_valid | r_t_valid;

endmodule

// ===== rtl/ffds_checker.sv =====
// Port-level checks for the farthest-first depth sorter, bound to the top level.
// Depends only on the top-level ports.
module ffds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_object,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [4:0]  o_object_index,
    input logic        o_has_object,
    input logic        o_last_result
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_object_index) && $stable(o_has_object)
         && $stable(o_last_result)))
        else $error("stalled result changed");

    // Every result is either an object or the terminator, never both.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_has_object != o_last_result))
        else $error("result kind flags inconsistent");

    // The terminator carries index zero.
    a_term_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> (o_object_index == 5'd0))
        else $error("terminator index not zero");

    // Loading stops once the final object of a list has been taken.
    a_run_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_object) |=> o_in_stall)
        else $error("input taken during a run");

endmodule

bind farthest_first_depth_sorter ffds_checker u_ffds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last_object  (i_last_object),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_object_index (o_object_index),
    .o_has_object   (o_has_object),
    .o_last_result  (o_last_result)
);
